[sv/sle_pkg.sv]
// Shared types, codes and constants of the string literal escape decoder.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    // Decoded length saturates here.
    localparam int unsigned LEN_W = 12;
    localparam logic [LEN_W-1:0] MAX_LENGTH = 12'd4095;

    // Depth of the record queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_LIMIT   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_ESCAPE_BYTE = 8'd92;
    localparam logic [7:0] RST_HEX_LIMIT   = 8'd127;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // End report status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY_HEX   = 3'd1;
    localparam logic [2:0] ST_HEX_OVER    = 3'd2;
    localparam logic [2:0] ST_TRAIL_ESC   = 3'd3;
    localparam logic [2:0] ST_MULTI_CHAR  = 3'd4;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd5;

    // Escape letters and the control codes they stand for.
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_V = 8'h76;
    localparam logic [7:0] CH_X = 8'h78;

    localparam logic [7:0] CC_BEL = 8'd7;
    localparam logic [7:0] CC_BS  = 8'd8;
    localparam logic [7:0] CC_HT  = 8'd9;
    localparam logic [7:0] CC_LF  = 8'd10;
    localparam logic [7:0] CC_VT  = 8'd11;
    localparam logic [7:0] CC_FF  = 8'd12;
    localparam logic [7:0] CC_CR  = 8'd13;

    // Hex accumulator is 9 bits and sticks at 256.
    localparam logic [8:0] HEX_SAT = 9'd256;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_first;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic [2:0]       status;
        logic [LEN_W-1:0] decoded_length;
        logic             last_of_run;
    } t_out_item;

    // Everything one input byte produces: one or two results.
    typedef struct packed {
        logic      two;
        t_out_item a;
        t_out_item b;
    } t_rec;

endpackage

`default_nettype wire

[sv/string_literal_escape_decoder.sv]
// Top level of the string literal escape decoder.
//
// This block takes a quoted string or character literal one byte per transfer
// (the opening quote flagged is_first, the closing quote flagged is_last) and
// returns the decoded bytes followed by one end report that carries the status
// and the saturating decoded length. The front end accepts one byte every clock
// cycle while the queue has room and decodes it in that cycle; each byte yields
// zero, one or two results, which go as one record into a four-entry queue; the
// back end drains that queue through an output register at one result per cycle
// while ready is high, handing out the results of a record in order. Sustained
// throughput is one byte per cycle as long as bytes average at most one result and
// the consumer keeps ready high. Input ready drops only when the queue is full.
// Configuration is written through a plain write port and takes effect at once;
// write it only while the block is idle. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module string_literal_escape_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire sle_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output sle_pkg::t_out_item                 o_out_item
);

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    sle_pkg::t_rec push_rec;
    sle_pkg::t_rec head_rec;

    // Front end: byte decode and literal state.
    sle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .i_item      (i_in_item),
        .o_ready     (o_in_ready),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_rec       (push_rec)
    );

    // Decouples the front end from output back pressure.
    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_rec),
        .i_pop   (q_pop)
    );

    // Back end: one result per transfer.
    sle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head_rec),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .o_item    (o_out_item),
        .i_ready   (i_out_ready)
    );

    // Every end report closes the run of results of its byte.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == sle_pkg::KIND_END) |-> o_out_item.last_of_run)
        else $error("end report not flagged as the last result");

endmodule

`default_nettype wire

[sv/sle_front.sv]
// Front end: accepts literal bytes, tracks escape state and builds result records.
`timescale 1ns / 1ps
`default_nettype none

module sle_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_valid,
    input  wire sle_pkg::t_in_item               i_item,
    output logic                                 o_ready,
    input  wire logic                            i_q_full,
    output logic                                 o_push,
    output sle_pkg::t_rec                        o_rec
);

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic [7:0]                r_escape_byte;
    logic                      r_char_mode;
    logic [7:0]                r_hex_limit;

    logic                      r_in_body,    n_in_body;
    logic                      r_esc_pend,   n_esc_pend;
    logic                      r_hex_active, n_hex_active;
    logic                      r_hex_seen,   n_hex_seen;
    logic [8:0]                r_hex_acc,    n_hex_acc;
    logic [2:0]                r_err,        n_err;
    logic [sle_pkg::LEN_W-1:0] r_count,      n_count;
    logic [7:0]                r_first_char, n_first_char;

    logic                      accept;
    logic [4:0]                hv;
    logic [12:0]               acc_ext;
    logic                      e1, e2, proceed, do_end, do_clear;
    logic [7:0]                e1b, e2b, b;
    logic [2:0]                end_status;
    logic [7:0]                end_data;
    logic [sle_pkg::LEN_W-1:0] end_len;
    sle_pkg::t_out_item [1:0]  slots;
    logic [1:0]                k;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_item.in_byte;
    assign hv      = hex_val(b);
    assign acc_ext = {r_hex_acc, 4'b0000} + {9'd0, hv[3:0]};

    always_comb begin
        n_in_body    = r_in_body;
        n_esc_pend   = r_esc_pend;
        n_hex_active = r_hex_active;
        n_hex_seen   = r_hex_seen;
        n_hex_acc    = r_hex_acc;
        n_err        = r_err;
        n_count      = r_count;
        n_first_char = r_first_char;
        e1 = 1'b0; e1b = 8'd0; e2 = 1'b0; e2b = 8'd0;
        proceed    = 1'b0;
        do_end     = 1'b0;
        do_clear   = 1'b0;
        end_status = sle_pkg::ST_OK;
        end_data   = 8'd0;
        end_len    = '0;

        if (accept) begin
            if (i_item.is_first) begin
                do_clear = 1'b1;
                if (i_item.is_last) begin
                    do_end     = 1'b1;
                    end_status = sle_pkg::ST_TOO_SHORT;
                end
            end else if (!r_in_body) begin
                if (i_item.is_last) begin
                    do_end     = 1'b1;
                    end_status = sle_pkg::ST_TOO_SHORT;
                end
            end else if (i_item.is_last) begin
                if (r_err == sle_pkg::ST_OK) begin
                    if (r_hex_active) begin
                        if (!r_hex_seen) begin
                            n_err = sle_pkg::ST_EMPTY_HEX;
                        end else if (r_hex_acc > {1'b0, r_hex_limit}) begin
                            n_err = sle_pkg::ST_HEX_OVER;
                        end else begin
                            e1  = 1'b1;
                            e1b = r_hex_acc[7:0];
                        end
                    end else if (r_esc_pend) begin
                        n_err = sle_pkg::ST_TRAIL_ESC;
                    end
                end
            end else if (r_err == sle_pkg::ST_OK) begin
                if (r_hex_active) begin
                    if (hv[4]) begin
                        n_hex_seen = 1'b1;
                        n_hex_acc  = (acc_ext > 13'(sle_pkg::HEX_SAT)) ?
                                     sle_pkg::HEX_SAT : acc_ext[8:0];
                    end else begin
                        // A non-hex byte closes the run and, if the run was valid, is then decoded normally.
                        n_hex_active = 1'b0;
                        if (!r_hex_seen) begin
                            n_err = sle_pkg::ST_EMPTY_HEX;
                        end else if (r_hex_acc > {1'b0, r_hex_limit}) begin
                            n_err = sle_pkg::ST_HEX_OVER;
                        end else begin
                            e1      = 1'b1;
                            e1b     = r_hex_acc[7:0];
                            proceed = 1'b1;
                        end
                    end
                end else begin
                    proceed = 1'b1;
                end

                if (proceed) begin
                    if (r_esc_pend) begin
                        n_esc_pend = 1'b0;
                        if (b == r_escape_byte) begin
                            e2 = 1'b1; e2b = b;
                        end else begin
                            unique case (b)
                                sle_pkg::CH_A: begin e2 = 1'b1; e2b = sle_pkg::CC_BEL; end
                                sle_pkg::CH_B: begin e2 = 1'b1; e2b = sle_pkg::CC_BS;  end
                                sle_pkg::CH_F: begin e2 = 1'b1; e2b = sle_pkg::CC_FF;  end
                                sle_pkg::CH_N: begin e2 = 1'b1; e2b = sle_pkg::CC_LF;  end
                                sle_pkg::CH_R: begin e2 = 1'b1; e2b = sle_pkg::CC_CR;  end
                                sle_pkg::CH_T: begin e2 = 1'b1; e2b = sle_pkg::CC_HT;  end
                                sle_pkg::CH_V: begin e2 = 1'b1; e2b = sle_pkg::CC_VT;  end
                                sle_pkg::CH_X: begin
                                    n_hex_active = 1'b1;
                                    n_hex_seen   = 1'b0;
                                    n_hex_acc    = 9'd0;
                                end
                                default: begin e2 = 1'b1; e2b = b; end
                            endcase
                        end
                    end else if (b == r_escape_byte) begin
                        n_esc_pend = 1'b1;
                    end else begin
                        e2 = 1'b1; e2b = b;
                    end
                end
            end

            // Count decoded bytes in order, remembering the first one.
            if (e1) begin
                if (n_count == '0) n_first_char = e1b;
                if (n_count < sle_pkg::MAX_LENGTH) n_count = n_count + 1'b1;
            end
            if (e2) begin
                if (n_count == '0) n_first_char = e2b;
                if (n_count < sle_pkg::MAX_LENGTH) n_count = n_count + 1'b1;
            end

            if (!i_item.is_first && r_in_body && i_item.is_last) begin
                do_end     = 1'b1;
                do_clear   = 1'b1;
                end_status = n_err;
                end_len    = n_count;
                if (end_status == sle_pkg::ST_OK && r_char_mode && n_count > 12'd1) begin
                    end_status = sle_pkg::ST_MULTI_CHAR;
                end
                if (end_status == sle_pkg::ST_OK && r_char_mode && n_count != '0) begin
                    end_data = n_first_char;
                end
            end

            if (do_clear) begin
                n_in_body    = i_item.is_first && !i_item.is_last;
                n_esc_pend   = 1'b0;
                n_hex_active = 1'b0;
                n_hex_seen   = 1'b0;
                n_hex_acc    = 9'd0;
                n_err        = sle_pkg::ST_OK;
                n_count      = '0;
                n_first_char = 8'd0;
            end
        end
    end

    // Pack the results of this byte into one record, in model order; character mode packs only the end report.
    always_comb begin
        slots = '0;
        k     = 2'd0;
        if (e1 && !r_char_mode) begin
            slots[k[0]].kind      = sle_pkg::KIND_DATA;
            slots[k[0]].data_byte = e1b;
            k = k + 2'd1;
        end
        if (e2 && !r_char_mode) begin
            slots[k[0]].kind      = sle_pkg::KIND_DATA;
            slots[k[0]].data_byte = e2b;
            k = k + 2'd1;
        end
        if (do_end) begin
            slots[k[0]].kind           = sle_pkg::KIND_END;
            slots[k[0]].data_byte      = end_data;
            slots[k[0]].status         = end_status;
            slots[k[0]].decoded_length = end_len;
            k = k + 2'd1;
        end
        if (k == 2'd1) begin
            slots[0].last_of_run = 1'b1;
        end else if (k == 2'd2) begin
            slots[1].last_of_run = 1'b1;
        end
    end

    assign o_push  = accept && (k != 2'd0);
    assign o_rec.two = (k == 2'd2);
    assign o_rec.a   = slots[0];
    assign o_rec.b   = slots[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_byte <= sle_pkg::RST_ESCAPE_BYTE;
            r_char_mode   <= 1'b0;
            r_hex_limit   <= sle_pkg::RST_HEX_LIMIT;
            r_in_body     <= 1'b0;
            r_esc_pend    <= 1'b0;
            r_hex_active  <= 1'b0;
            r_hex_seen    <= 1'b0;
            r_hex_acc     <= 9'd0;
            r_err         <= sle_pkg::ST_OK;
            r_count       <= '0;
            r_first_char  <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sle_pkg::CFG_ESCAPE_BYTE: r_escape_byte <= i_cfg_data;
                    sle_pkg::CFG_CHAR_MODE:   r_char_mode   <= i_cfg_data[0];
                    sle_pkg::CFG_HEX_LIMIT:   r_hex_limit   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_body    <= n_in_body;
            r_esc_pend   <= n_esc_pend;
            r_hex_active <= n_hex_active;
            r_hex_seen   <= n_hex_seen;
            r_hex_acc    <= n_hex_acc;
            r_err        <= n_err;
            r_count      <= n_count;
            r_first_char <= n_first_char;
        end
    end

    // An escape and a hex run are never open together.
    a_esc_hex_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_esc_pend && r_hex_active))
        else $error("escape pending during a hex run");

    // Escape state only exists inside a literal.
    a_state_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_esc_pend || r_hex_active || r_count != '0) |-> r_in_body)
        else $error("literal state outside a literal");

endmodule

`default_nettype wire

[sv/sle_queue.sv]
// Small record queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module sle_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sle_pkg::t_rec i_rec,
    output logic               o_full,
    output logic               o_valid,
    output sle_pkg::t_rec      o_head,
    input  wire logic          i_pop
);

    sle_pkg::t_rec                r_mem [sle_pkg::QUEUE_DEPTH];
    logic [sle_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [sle_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [sle_pkg::QCNT_W-1:0]   r_count;
    logic                         do_push, do_pop;

    assign o_full  = (r_count == sle_pkg::QCNT_W'(sle_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sle_pkg::QCNT_W'(sle_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("record pushed into a full queue");

endmodule

`default_nettype wire

[sv/sle_back.sv]
// Back end: unpacks queued records into single results behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module sle_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire sle_pkg::t_rec i_head,
    output logic               o_pop,
    output logic               o_valid,
    output sle_pkg::t_out_item o_item,
    input  wire logic          i_ready
);

    logic               r_sub;
    logic               r_valid;
    sle_pkg::t_out_item r_item;
    logic               load;

    assign load    = !r_valid || i_ready;
    assign o_pop   = load && i_q_valid && !(i_head.two && !r_sub);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_item <= r_sub ? i_head.b : i_head.a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 1'b0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_sub <= i_head.two && !r_sub;
            end
        end
    end

    // The second half of a record is only pending while that record heads the queue.
    a_sub_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (i_q_valid && i_head.two))
        else $error("second result pending without a two-result record");

endmodule

`default_nettype wire
